// ----- src/csvfs_pkg.sv -----
`timescale 1ns / 1ps

package csvfs_pkg;

    localparam logic [7:0] QUOTE_CHAR  = 8'h22;
    localparam logic [7:0] CR_CHAR     = 8'h0D;
    localparam logic [7:0] LF_CHAR     = 8'h0A;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] TAB_CHAR    = 8'h09;
    localparam logic [7:0] NUL_CHAR    = 8'h00;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    // one input word
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_of_line;
    } t_in_item;

    // one result word
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       field_end;
        logic       record_end;
    } t_result;

    // per-line parser flags
    typedef struct packed {
        logic in_quotes;
        logic quote_pending;
        logic field_empty;
        logic seen_nonblank;
        logic line_done;
    } t_line_state;

    localparam t_line_state LINE_RESET = '{
        in_quotes:     1'b0,
        quote_pending: 1'b0,
        field_empty:   1'b1,
        seen_nonblank: 1'b0,
        line_done:     1'b0
    };

endpackage

// ----- src/csvfs_intf.sv -----
`timescale 1ns / 1ps

interface csvfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_of_line;

    modport source (output valid, output char_in, output last_of_line, input ready);
    modport sink (input valid, input char_in, input last_of_line, output ready);
endinterface

interface csvfs_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       field_end;
    logic       record_end;

    modport source (output valid, output out_char, output char_valid,
                    output field_end, output record_end, input ready);
    modport sink (input valid, input out_char, input char_valid,
                  input field_end, input record_end, output ready);
endinterface

interface csvfs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] delimiter_char;

    modport source (output valid, output delimiter_char, input ready);
    modport sink (input valid, input delimiter_char, output ready);
endinterface

// ----- src/csvfs_in_stage.sv -----
`timescale 1ns / 1ps

module csvfs_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  csvfs_pkg::t_in_item i_item,
    output logic                o_ready,
    input  logic                i_advance,
    output logic                o_valid,
    output csvfs_pkg::t_in_item o_item
);

    logic                r_valid;
    csvfs_pkg::t_in_item r_item;
    logic                n_valid;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- src/csvfs_parse.sv -----
`timescale 1ns / 1ps

module csvfs_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_delim,
    input  logic                i_fire,
    input  csvfs_pkg::t_in_item i_item,
    output logic                o_emit,
    output csvfs_pkg::t_result  o_result
);

    csvfs_pkg::t_line_state r_state;
    csvfs_pkg::t_line_state n_state;
    logic [7:0]             r_delim;

    always_comb begin
        logic [7:0] c;
        logic       handled;
        c        = i_item.char_in;
        handled  = 1'b0;
        n_state  = r_state;
        o_result = '0;
        if (r_state.line_done) begin
            // rest of the line is dropped
            if (i_item.last_of_line) begin
                n_state = csvfs_pkg::LINE_RESET;
            end
        end else begin
            if (r_state.quote_pending) begin
                n_state.quote_pending = 1'b0;
                if (c == csvfs_pkg::QUOTE_CHAR) begin
                    // doubled quote
                    n_state.field_empty   = 1'b0;
                    n_state.seen_nonblank = 1'b1;
                    o_result.out_char     = c;
                    o_result.char_valid   = 1'b1;
                    handled               = 1'b1;
                end else begin
                    n_state.in_quotes = 1'b0;
                end
            end
            if (!handled) begin
                if (c == csvfs_pkg::NUL_CHAR) begin
                    o_result.field_end  = 1'b1;
                    o_result.record_end = 1'b1;
                end else if (!n_state.in_quotes && n_state.field_empty
                             && c == csvfs_pkg::QUOTE_CHAR) begin
                    n_state.in_quotes = 1'b1;
                end else if (n_state.in_quotes && c == csvfs_pkg::QUOTE_CHAR) begin
                    n_state.quote_pending = 1'b1;
                end else if (!n_state.in_quotes && c == r_delim) begin
                    o_result.field_end    = 1'b1;
                    n_state.field_empty   = 1'b1;
                    n_state.seen_nonblank = 1'b0;
                end else if (!n_state.in_quotes
                             && (c == csvfs_pkg::CR_CHAR || c == csvfs_pkg::LF_CHAR)) begin
                    o_result.field_end  = 1'b1;
                    o_result.record_end = 1'b1;
                end else begin
                    n_state.field_empty = 1'b0;
                    if (r_state.seen_nonblank
                        || (c != csvfs_pkg::SPACE_CHAR && c != csvfs_pkg::TAB_CHAR)) begin
                        n_state.seen_nonblank = 1'b1;
                        o_result.out_char     = c;
                        o_result.char_valid   = 1'b1;
                    end
                end
            end
            if (i_item.last_of_line) begin
                o_result.field_end  = 1'b1;
                o_result.record_end = 1'b1;
                n_state             = csvfs_pkg::LINE_RESET;
            end else if (o_result.record_end) begin
                n_state           = csvfs_pkg::LINE_RESET;
                n_state.line_done = 1'b1;
            end
        end
        o_emit = o_result.char_valid || o_result.field_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csvfs_pkg::LINE_RESET;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= csvfs_pkg::DELIM_RESET;
        end else if (i_cfg_we) begin
            r_delim <= i_cfg_delim;
        end
    end

endmodule

// ----- src/csvfs_out_reg.sv -----
`timescale 1ns / 1ps

module csvfs_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_emit,
    input  csvfs_pkg::t_result i_result,
    output logic               o_can_load,
    input  logic               i_ready,
    output logic               o_valid,
    output csvfs_pkg::t_result o_result
);

    logic               r_valid;
    csvfs_pkg::t_result r_result;
    logic               n_valid;

    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load && i_emit) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- src/csv_line_field_splitter_top.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// i_item    in   valid/ready    char_in[7:0], last_of_line
// o_result  out  valid/ready    out_char[7:0], char_valid, field_end, record_end
// i_cfg     in   valid/ready    delimiter_char[7:0] (ready always high)
//
// one word per cycle sustained while o_result does not stall; an accepted word is held
// in the input register, then parsed and loaded into the result register that drives o_result
// silent words (opening or pending quote, leading blank, bytes after the record
// ended) are dropped inside and never reach o_result
// i_rst_n is synchronous: line flags clear, delimiter returns to comma
// a stall on o_result holds the result register; one more word waits in the
// input register, then i_item.ready drops

module csv_line_field_splitter_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    csvfs_byte_if.sink            i_item,
    csvfs_result_if.source        o_result,
    csvfs_cfg_if.sink             i_cfg
);

    csvfs_pkg::t_in_item in_word;
    csvfs_pkg::t_in_item staged_word;
    csvfs_pkg::t_result  parse_result;
    csvfs_pkg::t_result  out_word;
    logic                staged_valid;
    logic                advance;
    logic                emit;
    logic                out_can_load;
    logic                cfg_we;

    assign in_word.char_in      = i_item.char_in;
    assign in_word.last_of_line = i_item.last_of_line;

    // config is always taken; the user must see that it is only written while the block is idle, the block has no check
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // staged word moves on whenever the result register has room
    assign advance = staged_valid && out_can_load;

    csvfs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_item.valid),
        .i_item    (in_word),
        .o_ready   (i_item.ready),
        .i_advance (advance),
        .o_valid   (staged_valid),
        .o_item    (staged_word)
    );

    // line flags and delimiter register, step logic for one byte
    csvfs_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_delim (i_cfg.delimiter_char),
        .i_fire      (advance),
        .i_item      (staged_word),
        .o_emit      (emit),
        .o_result    (parse_result)
    );

    csvfs_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_emit     (emit),
        .i_result   (parse_result),
        .o_can_load (out_can_load),
        .i_ready    (o_result.ready),
        .o_valid    (o_result.valid),
        .o_result   (out_word)
    );

    assign o_result.out_char   = out_word.out_char;
    assign o_result.char_valid = out_word.char_valid;
    assign o_result.field_end  = out_word.field_end;
    assign o_result.record_end = out_word.record_end;

endmodule
